// File: src/gcnp_pkg.sv
// shared types and constants of the core-number peeler
package gcnp_pkg;

    localparam int FIELD_W = 16;
    localparam int LEVEL_W = 10;

    typedef struct packed {
        logic [FIELD_W-1:0] end_a;
        logic [FIELD_W-1:0] end_b;
        logic               final_edge;
    } t_in_word;

    typedef struct packed {
        logic [FIELD_W-1:0] vertex_id;
        logic [LEVEL_W-1:0] core_number;
        logic [LEVEL_W-1:0] degeneracy;
        logic               capacity_overflow;
        logic               last_vertex;
    } t_out_word;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic level_up;
        logic scan_start;
        logic scan;
        logic remove;
        logic emit_start;
        logic emit;
        logic clear;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic empty;
        logic scan_done;
        logic any_remove;
        logic all_gone;
        logic emit_last;
        logic out_free;
    } t_sts;

endpackage

// File: src/gcnp_ifs.sv
// valid/ready channel interfaces for edge input and vertex results
interface gcnp_in_if;
    import gcnp_pkg::*;
    logic     valid;
    logic     ready;
    t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface gcnp_out_if;
    import gcnp_pkg::*;
    logic      valid;
    logic      ready;
    t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: src/graph_core_number_peeler.sv
// top level of the core-number peeler
//
//  channel  | dir | payload                                              | words
//  i_in     | in  | end_a, end_b, final_edge                             | one edge
//  o_out    | out | vertex_id, core_number, degeneracy, overflow, last   | one vertex
//
// an edge is loaded by a parallel id match and an edge ram write
// after the final edge each peeling pass walks the edge ram, one edge a cycle,
// and the pass is repeated per removal step and level
// results leave at one per cycle while o_out is ready, then a clear state follows
// i_in is not ready from the final edge until that clear state has passed
// reset is synchronous, active low; no clearing pass is needed
module graph_core_number_peeler #(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_EDGES    = 256,
    parameter int ID_BITS      = 16
) (
    input logic  i_clk,
    input logic  i_rst_n,
    gcnp_in_if.sink    i_in,
    gcnp_out_if.source o_out
);
    import gcnp_pkg::*;

    t_cmd cmd;
    t_sts sts;

    gcnp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_final (i_in.data.final_edge),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    gcnp_dpath #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES),
        .ID_BITS      (ID_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in.data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_out_data  (o_out.data)
    );

    a_hold_while_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> o_out.valid && $stable(o_out.data))
        else $error("result word changed while stalled");

    a_no_load_mid_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !(o_out.valid && !o_out.data.last_vertex))
        else $error("edge load open while results pending");

    a_core_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.data.core_number <= o_out.data.degeneracy))
        else $error("core number above degeneracy");
endmodule

// File: src/gcnp_ram.sv
// generic single-write, single-read ram with registered read data
module gcnp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

// File: src/gcnp_ctrl.sv
// sequencer: load, degree scans, removal steps, result emit, clear
module gcnp_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_final,
    output logic           o_in_ready,
    input  gcnp_pkg::t_sts i_sts,
    output gcnp_pkg::t_cmd o_cmd
);
    import gcnp_pkg::*;

    typedef enum logic [5:0] {
        S_LOAD   = 6'b000001,
        S_START  = 6'b000010,
        S_SCAN   = 6'b000100,
        S_REMOVE = 6'b001000,
        S_EMIT   = 6'b010000,
        S_CLEAR  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   accept;

    assign o_in_ready = (r_state == S_LOAD);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_LOAD: begin
                o_cmd.load = accept;
                if (accept && i_in_final) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                if (i_sts.empty) begin
                    n_state = S_CLEAR;
                end else begin
                    o_cmd.level_up   = 1'b1;
                    o_cmd.scan_start = 1'b1;
                    n_state          = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_REMOVE;
                end
            end
            S_REMOVE: begin
                if (i_sts.any_remove) begin
                    o_cmd.remove     = 1'b1;
                    o_cmd.scan_start = 1'b1;
                    n_state          = S_SCAN;
                end else if (i_sts.all_gone) begin
                    o_cmd.emit_start = 1'b1;
                    n_state          = S_EMIT;
                end else begin
                    o_cmd.level_up   = 1'b1;
                    o_cmd.scan_start = 1'b1;
                    n_state          = S_SCAN;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.emit_last) begin
                        n_state = S_CLEAR;
                    end
                end
            end
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                n_state     = S_LOAD;
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

// File: src/gcnp_dpath.sv
// vertex table, edge store, degree counters, removal and output register
module gcnp_dpath #(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_EDGES    = 256,
    parameter int ID_BITS      = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gcnp_pkg::t_in_word  i_in_data,
    input  gcnp_pkg::t_cmd      i_cmd,
    output gcnp_pkg::t_sts      o_sts,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output gcnp_pkg::t_out_word o_out_data
);
    import gcnp_pkg::*;

    localparam int SLOT_W  = $clog2(MAX_VERTICES);
    localparam int VCNT_W  = $clog2(MAX_VERTICES + 1);
    localparam int ECNT_W  = $clog2(MAX_EDGES + 1);
    localparam int EADDR_W = MAX_EDGES > 1 ? $clog2(MAX_EDGES) : 1;
    localparam int DEG_W   = $clog2(2 * MAX_EDGES + 1);
    localparam logic [FIELD_W-1:0] ID_MASK =
        (ID_BITS >= FIELD_W) ? {FIELD_W{1'b1}} : FIELD_W'((64'd1 << ID_BITS) - 64'd1);

    logic [FIELD_W-1:0] r_ids  [MAX_VERTICES];
    logic [DEG_W-1:0]   r_deg  [MAX_VERTICES];
    logic [LEVEL_W-1:0] r_core [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] r_gone;
    logic [VCNT_W-1:0]  r_vcount;
    logic [ECNT_W-1:0]  r_ecount;
    logic [ECNT_W-1:0]  r_scan_addr;
    logic               r_rd_pend;
    logic [LEVEL_W-1:0] r_level;
    logic               r_ovf;
    logic [SLOT_W-1:0]  r_emit_idx;
    logic               r_out_valid;
    t_out_word          r_out;

    logic [FIELD_W-1:0] id_a, id_b;
    logic [MAX_VERTICES-1:0] match_a, match_b, alive, rm;
    logic [SLOT_W-1:0]  hit_a, hit_b, slot_a, slot_b, edge_a, edge_b;
    logic               new_a, new_b, same, edge_ok, vert_ok, do_load, issue, live_edge;
    logic [VCNT_W:0]    need_sum;
    logic [2*SLOT_W-1:0] rd_data;

    assign id_a = i_in_data.end_a & ID_MASK;
    assign id_b = i_in_data.end_b & ID_MASK;
    assign same = (id_a == id_b);

    // parallel id match over the filled slots
    always_comb begin
        hit_a = '0;
        hit_b = '0;
        for (int i = 0; i < MAX_VERTICES; i++) begin
            match_a[i] = (VCNT_W'(i) < r_vcount) && (r_ids[i] == id_a);
            match_b[i] = (VCNT_W'(i) < r_vcount) && (r_ids[i] == id_b);
            hit_a      = hit_a | (match_a[i] ? SLOT_W'(i) : '0);
            hit_b      = hit_b | (match_b[i] ? SLOT_W'(i) : '0);
        end
    end

    assign new_a    = ~|match_a;
    assign new_b    = ~|match_b && !same;
    assign need_sum = {1'b0, r_vcount} + (VCNT_W + 1)'(new_a) + (VCNT_W + 1)'(new_b);
    assign edge_ok  = r_ecount < ECNT_W'(MAX_EDGES);
    assign vert_ok  = need_sum <= (VCNT_W + 1)'(MAX_VERTICES);
    assign do_load  = i_cmd.load && edge_ok && vert_ok;
    assign slot_a   = new_a ? r_vcount[SLOT_W-1:0] : hit_a;
    assign slot_b   = same ? slot_a :
                      (new_b ? SLOT_W'(r_vcount + VCNT_W'(new_a)) : hit_b);

    // edge scan reads one stored edge a cycle
    assign issue = i_cmd.scan && (r_scan_addr < r_ecount);

    gcnp_ram #(
        .WIDTH (2 * SLOT_W),
        .DEPTH (MAX_EDGES)
    ) u_edges (
        .i_clk   (i_clk),
        .i_we    (do_load),
        .i_waddr (r_ecount[EADDR_W-1:0]),
        .i_wdata ({slot_b, slot_a}),
        .i_re    (issue),
        .i_raddr (r_scan_addr[EADDR_W-1:0]),
        .o_rdata (rd_data)
    );

    assign edge_a    = rd_data[SLOT_W-1:0];
    assign edge_b    = rd_data[2*SLOT_W-1:SLOT_W];
    // an edge is gone exactly when one of its ends is gone
    assign live_edge = r_rd_pend && !r_gone[edge_a] && !r_gone[edge_b];

    always_comb begin
        for (int i = 0; i < MAX_VERTICES; i++) begin
            alive[i] = (VCNT_W'(i) < r_vcount) && !r_gone[i];
            rm[i]    = alive[i] && (32'(r_deg[i]) <= 32'(r_level));
        end
    end

    assign o_sts.empty      = (r_vcount == '0);
    assign o_sts.scan_done  = (r_scan_addr == r_ecount) && !r_rd_pend;
    assign o_sts.any_remove = |rm;
    assign o_sts.all_gone   = ~|alive;
    assign o_sts.emit_last  = (VCNT_W'(r_emit_idx) + VCNT_W'(1)) == r_vcount;
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (do_load && new_a) begin
            r_ids[r_vcount[SLOT_W-1:0]] <= id_a;
        end
        if (do_load && new_b) begin
            r_ids[slot_b] <= id_b;
        end
        for (int i = 0; i < MAX_VERTICES; i++) begin
            if (i_cmd.scan_start) begin
                r_deg[i] <= '0;
            end else if (live_edge) begin
                r_deg[i] <= r_deg[i] + DEG_W'(edge_a == SLOT_W'(i))
                                     + DEG_W'(edge_b == SLOT_W'(i));
            end
            if (i_cmd.remove && rm[i]) begin
                r_core[i] <= r_level;
            end
        end
        if (i_cmd.emit) begin
            r_out.vertex_id         <= r_ids[r_emit_idx];
            r_out.core_number       <= r_core[r_emit_idx];
            r_out.degeneracy        <= r_level;
            r_out.capacity_overflow <= r_ovf;
            r_out.last_vertex       <= o_sts.emit_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gone      <= '0;
            r_vcount    <= '0;
            r_ecount    <= '0;
            r_scan_addr <= '0;
            r_rd_pend   <= 1'b0;
            r_level     <= '0;
            r_ovf       <= 1'b0;
            r_emit_idx  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_pend <= issue;
            if (i_cmd.clear) begin
                r_gone   <= '0;
                r_vcount <= '0;
                r_ecount <= '0;
                r_level  <= '0;
                r_ovf    <= 1'b0;
            end else begin
                if (do_load) begin
                    r_vcount <= need_sum[VCNT_W-1:0];
                    r_ecount <= r_ecount + ECNT_W'(1);
                end else if (i_cmd.load) begin
                    r_ovf <= 1'b1;
                end
                if (i_cmd.remove) begin
                    r_gone <= r_gone | rm;
                end
                if (i_cmd.level_up) begin
                    r_level <= r_level + LEVEL_W'(1);
                end
            end
            if (i_cmd.scan_start) begin
                r_scan_addr <= '0;
            end else if (issue) begin
                r_scan_addr <= r_scan_addr + ECNT_W'(1);
            end
            if (i_cmd.emit_start) begin
                r_emit_idx <= '0;
            end else if (i_cmd.emit) begin
                r_emit_idx <= r_emit_idx + SLOT_W'(1);
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
endmodule

// File: test/gcnp_scoreboard.sv
// scoreboard for the core-number peeler: predicts vertex results from accepted edges
`timescale 1ns / 100ps
import gcnp_pkg::*;

class gcnp_scoreboard;
    localparam int NV = 64;
    localparam int NE = 256;
    localparam int LEVEL_CAP = 1023;

    logic [15:0] vid [NV];
    int          ea [NE];
    int          eb [NE];
    int          n_edge;
    int          n_vert;
    bit          ovf;
    t_out_word   pending[$];
    int          errors;
    int          n_graphs;
    int          n_results;

    function new();
        errors = 0;
        n_graphs = 0;
        n_results = 0;
        wipe();
    endfunction

    function void wipe();
        n_edge = 0;
        n_vert = 0;
        ovf = 0;
    endfunction

    function int slot_of(logic [15:0] id);
        for (int i = 0; i < n_vert; i++)
            if (vid[i] == id) return i;
        return -1;
    endfunction

    function void add_edge(logic [15:0] a, logic [15:0] b);
        int sa;
        int sb;
        int need;
        if (n_edge >= NE) begin
            ovf = 1;
            return;
        end
        sa = slot_of(a);
        sb = slot_of(b);
        need = (sa < 0) + ((sb < 0 && a != b) ? 1 : 0);
        if (n_vert + need > NV) begin
            ovf = 1;
            return;
        end
        if (sa < 0) begin
            vid[n_vert] = a;
            sa = n_vert++;
        end
        if (sb < 0 && a == b) sb = sa;
        if (sb < 0) begin
            vid[n_vert] = b;
            sb = n_vert++;
        end
        ea[n_edge] = sa;
        eb[n_edge] = sb;
        n_edge++;
    endfunction

    // k-core peel, then queue one result per vertex
    function void peel_and_queue();
        bit   vgone [NV];
        bit   egone [NE];
        int   degr [NV];
        int   core [NV];
        int   left;
        int   removed;
        int   k;
        t_out_word w;
        for (int i = 0; i < NV; i++) vgone[i] = 0;
        for (int j = 0; j < NE; j++) egone[j] = 0;
        left = n_vert;
        k = 0;
        while (left > 0) begin
            k++;
            do begin
                for (int i = 0; i < n_vert; i++) begin
                    degr[i] = 0;
                    if (vgone[i]) continue;
                    for (int j = 0; j < n_edge; j++) begin
                        if (egone[j]) continue;
                        if (ea[j] == i) degr[i]++;
                        if (eb[j] == i) degr[i]++;
                    end
                end
                removed = 0;
                for (int i = 0; i < n_vert; i++) begin
                    if (vgone[i] || degr[i] > k) continue;
                    core[i] = k;
                    vgone[i] = 1;
                    for (int j = 0; j < n_edge; j++)
                        if (ea[j] == i || eb[j] == i) egone[j] = 1;
                    removed++;
                end
                left -= removed;
            end while (removed > 0);
        end
        for (int i = 0; i < n_vert; i++) begin
            w.vertex_id = vid[i];
            w.core_number = LEVEL_W'((core[i] > LEVEL_CAP) ? LEVEL_CAP : core[i]);
            w.degeneracy = LEVEL_W'((k > LEVEL_CAP) ? LEVEL_CAP : k);
            w.capacity_overflow = ovf;
            w.last_vertex = (i + 1 == n_vert);
            pending = {pending, w};
        end
        n_graphs++;
        wipe();
    endfunction

    function void note_edge(t_in_word e);
        add_edge(e.end_a, e.end_b);
        if (e.final_edge) peel_and_queue();
    endfunction

    task report(string what);
        errors++;
        $display("mismatch: %s", what);
    endtask

    task check_vertex(t_out_word got);
        t_out_word want;
        n_results++;
        if (pending.size() == 0) begin
            report($sformatf("unexpected vertex word %h", got));
            return;
        end
        want = pending.pop_front();
        if (got.vertex_id !== want.vertex_id)
            report($sformatf("vertex_id %h want %h", got.vertex_id, want.vertex_id));
        if (got.core_number !== want.core_number)
            report($sformatf("core %0d want %0d (v %h)", got.core_number,
                             want.core_number, want.vertex_id));
        if (got.degeneracy !== want.degeneracy)
            report($sformatf("degeneracy %0d want %0d", got.degeneracy, want.degeneracy));
        if (got.capacity_overflow !== want.capacity_overflow)
            report($sformatf("overflow %b want %b", got.capacity_overflow,
                             want.capacity_overflow));
        if (got.last_vertex !== want.last_vertex)
            report($sformatf("last %b want %b", got.last_vertex, want.last_vertex));
    endtask
endclass

// File: test/testbench.sv
// testbench top for the core-number peeler: directed and random edge lists
`timescale 1ns / 100ps
import gcnp_pkg::*;

module testbench;
    logic i_clk;
    logic i_rst_n;
    int   idle_pct;
    int   stall_pct;
    int   n_items;

    gcnp_in_if  in_ch ();
    gcnp_out_if out_ch ();
    gcnp_scoreboard vertex_board;

    graph_core_number_peeler dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("TB_ERROR");
        $finish;
    end

    // result side: random stall, check on handshake
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 0;
        end else begin
            if (out_ch.valid && out_ch.ready) vertex_board.check_vertex(out_ch.data);
            out_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // valid stays up between back-to-back words and drops only while idling
    task send_edge(logic [15:0] a, logic [15:0] b, bit fin);
        while ($urandom_range(99) < idle_pct) begin
            in_ch.valid <= 0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1;
        in_ch.data <= '{end_a: a, end_b: b, final_edge: fin};
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        vertex_board.note_edge(in_ch.data);
        n_items++;
    endtask

    // random graph: mostly few ids so cores grow, sometimes wide ids
    task random_graph(int n_edges, int id_span);
        logic [15:0] a;
        logic [15:0] b;
        for (int i = 0; i < n_edges; i++) begin
            a = (id_span == 0) ? 16'($urandom) : 16'($urandom_range(id_span));
            b = ($urandom_range(9) == 0) ? a :
                ((id_span == 0) ? 16'($urandom) : 16'($urandom_range(id_span)));
            send_edge(a, b, i == n_edges - 1);
        end
    endtask

    task set_phase(int p);
        case (p % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 75; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 75; end
            default: begin idle_pct = 8; stall_pct = 8; end
        endcase
    endtask

    initial begin
        int wait_cycles;
        vertex_board = new();
        idle_pct = 0;
        stall_pct = 0;
        n_items = 0;
        i_rst_n = 0;
        in_ch.valid = 0;
        in_ch.data = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: single self-loop, extreme ids, triangle with pendant, duplicates
        send_edge(16'hFFFF, 16'hFFFF, 1);
        send_edge(16'h0000, 16'hFFFF, 1);
        send_edge(16'h5555, 16'hAAAA, 0);
        send_edge(16'hAAAA, 16'h1234, 0);
        send_edge(16'h1234, 16'h5555, 0);
        send_edge(16'h1234, 16'h0007, 1);
        send_edge(16'h0001, 16'h0002, 0);
        send_edge(16'h0001, 16'h0002, 0);
        send_edge(16'h0001, 16'h0002, 0);
        send_edge(16'h0003, 16'h0003, 1);
        // complete graph on 5 vertices: core 4
        for (int i = 0; i < 5; i++)
            for (int j = i + 1; j < 5; j++)
                send_edge(16'(i + 10), 16'(j + 10), (i == 3));

        // vertex overflow: 66 distinct ids, then an edge with all known ids
        for (int i = 0; i < 33; i++) send_edge(16'(2 * i + 100), 16'(2 * i + 101), 0);
        send_edge(16'd100, 16'd101, 1);

        // random graphs across idling and stalling phases
        for (int g = 0; g < 8; g++) begin
            set_phase(g / 2);
            if (g % 5 == 4) random_graph($urandom_range(1, 6), 0);
            else random_graph($urandom_range(2, 10), $urandom_range(3, 12));
        end
        in_ch.valid <= 0;
        set_phase(0);

        wait_cycles = 0;
        while (vertex_board.pending.size() != 0 && wait_cycles < 200000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (100) @(posedge i_clk);
        $display("graphs peeled: %0d, edges sent: %0d, vertex results checked: %0d",
                 vertex_board.n_graphs, n_items, vertex_board.n_results);
        if (vertex_board.errors == 0 && vertex_board.pending.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

// File: filelist.f
src/gcnp_pkg.sv
src/gcnp_ifs.sv
src/gcnp_ram.sv
src/gcnp_ctrl.sv
src/gcnp_dpath.sv
src/graph_core_number_peeler.sv
test/gcnp_scoreboard.sv
test/testbench.sv
